// ===== rtl/core/kbd_s2a_pkg.sv =====
// Shared types, constants and the make-code character table for the
// set-1 scancode decoder. No dependencies.
`default_nettype none

package kbd_s2a_pkg;

    // Modifier event codes carried on the result word
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_SHIFT   = 3'd1;
    localparam logic [2:0] EV_CONTROL = 3'd2;
    localparam logic [2:0] EV_META    = 3'd3;
    localparam logic [2:0] EV_ALT     = 3'd4;
    localparam logic [2:0] EV_CAPS    = 3'd5;

    // Modifier make codes
    localparam logic [6:0] SC_LSHIFT  = 7'h2A;
    localparam logic [6:0] SC_RSHIFT  = 7'h36;
    localparam logic [6:0] SC_CONTROL = 7'h1D;
    localparam logic [6:0] SC_LMETA   = 7'h5B;
    localparam logic [6:0] SC_RMETA   = 7'h5C;
    localparam logic [6:0] SC_ALT     = 7'h38;
    localparam logic [6:0] SC_CAPS    = 7'h3A;

    localparam logic [6:0] ASCII_SPACE = 7'h20;
    localparam logic [6:0] ASCII_TILDE = 7'h7E;
    localparam logic [6:0] ASCII_LC_A  = 7'h61;
    localparam logic [6:0] ASCII_LC_Z  = 7'h7A;
    localparam logic [6:0] CASE_OFFSET = 7'h20;

    typedef struct packed {
        logic shift;
        logic control;
        logic alt;
        logic meta;
        logic caps;
    } t_mod_flags;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic [2:0] modifier_event;
        logic       caps_lock_on;
        logic       is_release;
    } t_result;

    // Make code to ASCII; zero marks a key that is not a character key
    function automatic logic [6:0] char_map(input logic [6:0] code);
        logic [6:0] c;
        c = 7'h00;
        case (code)
            7'h01: c = 7'h1B;
            7'h02: c = 7'h31;
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0A: c = 7'h39;
            7'h0B: c = 7'h30;
            7'h0C: c = 7'h2D;
            7'h0D: c = 7'h3D;
            7'h0E: c = 7'h7F;
            7'h0F: c = 7'h09;
            7'h10: c = 7'h71;
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6F;
            7'h19: c = 7'h70;
            7'h1A: c = 7'h5B;
            7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h61;
            7'h1F: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6A;
            7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;
            7'h27: c = 7'h3B;
            7'h28: c = 7'h27;
            7'h2B: c = 7'h5C;
            7'h2C: c = 7'h7A;
            7'h2D: c = 7'h78;
            7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6E;
            7'h32: c = 7'h6D;
            7'h33: c = 7'h2C;
            7'h34: c = 7'h2E;
            7'h35: c = 7'h2F;
            7'h39: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kbd_s2a_decode.sv =====
// Combinational decode of one scancode against the current modifier flags.
// Uses kbd_s2a_pkg for the character table, event codes and flag types.
`default_nettype none

module kbd_s2a_decode (
    input  wire logic [7:0]             i_code,
    input  wire kbd_s2a_pkg::t_mod_flags i_flags,
    output kbd_s2a_pkg::t_mod_flags     o_flags,
    output kbd_s2a_pkg::t_result        o_result
);

    logic [6:0] mk;
    logic [6:0] raw_c;
    logic [6:0] up_c;
    logic       any_mod;
    logic       printable;

    assign mk      = i_code[6:0];
    assign raw_c   = kbd_s2a_pkg::char_map(mk);
    assign any_mod = i_flags.shift | i_flags.control | i_flags.alt | i_flags.meta;

    always_comb begin
        up_c = raw_c;
        if (i_flags.caps && raw_c >= kbd_s2a_pkg::ASCII_LC_A &&
            raw_c <= kbd_s2a_pkg::ASCII_LC_Z) begin
            up_c = raw_c - kbd_s2a_pkg::CASE_OFFSET;
        end
    end

    // a zero table entry is below space, so it fails this test too
    assign printable = (up_c >= kbd_s2a_pkg::ASCII_SPACE) &&
                       (up_c <= kbd_s2a_pkg::ASCII_TILDE);

    always_comb begin
        o_flags                 = i_flags;
        o_result.char_valid     = 1'b0;
        o_result.char_code      = 7'h00;
        o_result.modifier_event = kbd_s2a_pkg::EV_NONE;
        o_result.is_release     = 1'b0;
        if (i_code[7]) begin
            // break code: drop the held modifiers, caps lock stays
            o_result.is_release = 1'b1;
            o_flags.shift       = 1'b0;
            o_flags.control     = 1'b0;
            o_flags.alt         = 1'b0;
            o_flags.meta        = 1'b0;
        end else begin
            priority if (mk == kbd_s2a_pkg::SC_LSHIFT || mk == kbd_s2a_pkg::SC_RSHIFT) begin
                o_flags.shift           = 1'b1;
                o_result.modifier_event = kbd_s2a_pkg::EV_SHIFT;
            end else if (mk == kbd_s2a_pkg::SC_CONTROL) begin
                o_flags.control         = 1'b1;
                o_result.modifier_event = kbd_s2a_pkg::EV_CONTROL;
            end else if (mk == kbd_s2a_pkg::SC_LMETA || mk == kbd_s2a_pkg::SC_RMETA) begin
                o_flags.meta            = 1'b1;
                o_result.modifier_event = kbd_s2a_pkg::EV_META;
            end else if (mk == kbd_s2a_pkg::SC_ALT) begin
                o_flags.alt             = 1'b1;
                o_result.modifier_event = kbd_s2a_pkg::EV_ALT;
            end else if (mk == kbd_s2a_pkg::SC_CAPS) begin
                o_flags.caps            = ~i_flags.caps;
                o_result.modifier_event = kbd_s2a_pkg::EV_CAPS;
            end else begin
                if (!any_mod && printable) begin
                    o_result.char_valid = 1'b1;
                    o_result.char_code  = up_c;
                end
            end
        end
        o_result.caps_lock_on = o_flags.caps;
    end

endmodule

`default_nettype wire

// ===== rtl/core/keyboard_scancode_to_ascii.sv =====
// Each accepted scancode passes the input register, then the result register.
// Throughput: one scancode per cycle while i_stall does not hold the result
// word; the input register feeds a single table lookup and flag update that
// loads the result register and modifier flags.
// Reset (synchronous, active low) empties both registers and clears all five
// modifier flags; the block can accept a word as soon as reset is released.
`default_nettype none

module keyboard_scancode_to_ascii (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_scancode,
    output logic            o_stall,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_char_valid,
    output logic [6:0]      o_char_code,
    output logic [2:0]      o_modifier_event,
    output logic            o_caps_lock_on,
    output logic            o_is_release
);

    logic                    r_in_valid;
    logic [7:0]              r_in_code;
    logic                    r_out_valid;
    kbd_s2a_pkg::t_result    r_out;
    kbd_s2a_pkg::t_mod_flags r_flags;
    kbd_s2a_pkg::t_mod_flags n_flags;
    kbd_s2a_pkg::t_result    n_out;
    logic                    out_free;
    logic                    advance;

    // result register can take a word when empty or being drained
    assign out_free = ~r_out_valid | ~i_stall;
    assign advance  = r_in_valid & out_free;
    assign o_stall  = r_in_valid & ~out_free;

    kbd_s2a_decode u_decode (
        .i_code   (r_in_code),
        .i_flags  (r_flags),
        .o_flags  (n_flags),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_code <= i_scancode;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_char_valid     = r_out.char_valid;
    assign o_char_code      = r_out.char_code;
    assign o_modifier_event = r_out.modifier_event;
    assign o_caps_lock_on   = r_out.caps_lock_on;
    assign o_is_release     = r_out.is_release;

endmodule

`default_nettype wire

// ===== rtl/core/kbd_s2a_checker.sv =====
// Port-level checks for the scancode decoder, bound to its top level.
// Uses kbd_s2a_pkg for the event codes and character range.
`default_nettype none

module kbd_s2a_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_char_valid,
    input wire logic [6:0] o_char_code,
    input wire logic [2:0] o_modifier_event,
    input wire logic       o_caps_lock_on,
    input wire logic       o_is_release
);

    // a word held by the sink keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_valid) && $stable(o_char_code) &&
        $stable(o_modifier_event) && $stable(o_caps_lock_on) && $stable(o_is_release))
        else $error("stalled result word changed");

    // a character word is a plain press: no modifier event, no release
    a_char_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_char_valid |->
        o_modifier_event == kbd_s2a_pkg::EV_NONE && !o_is_release)
        else $error("character reported together with modifier or release");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_char_valid |->
        o_char_code >= kbd_s2a_pkg::ASCII_SPACE && o_char_code <= kbd_s2a_pkg::ASCII_TILDE)
        else $error("reported character not printable");

    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_char_code == 7'h00)
        else $error("character code set without a character");

    a_release_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_release |-> o_modifier_event == kbd_s2a_pkg::EV_NONE)
        else $error("release word carries a modifier event");

endmodule

bind keyboard_scancode_to_ascii kbd_s2a_checker u_kbd_s2a_checker (.*);

`default_nettype wire
